>>> src/mks_pkg.sv
// Shared types and constants of the matrix keypad scanner.
package mks_pkg;

    localparam int HIST_BITS  = 4;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_COLS   = 4;
    localparam int NUM_KEYS   = NUM_ROWS * NUM_COLS;
    localparam int NUM_REGS   = NUM_KEYS / 2;
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int COL_W      = $clog2(NUM_COLS);
    localparam int KEY_W      = $clog2(NUM_KEYS);
    localparam int REG_W      = $clog2(NUM_REGS);
    localparam int CODE_W     = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [CFG_W-1:0]  cfg_word_t;

    // Default map: '1' '2' '3' up / '4' '5' '6' left / '7' '8' '9' down / '0' esc cr right.
    localparam logic [NUM_REGS-1:0][CFG_W-1:0] KEYCODE_RESET = {
        16'd9997, 16'd6960, 16'd10297, 16'd14391,
        16'd9526, 16'd13620, 16'd9779, 16'd12849
    };

    // One scanned row as handed from the front end to the result stage.
    typedef struct packed {
        logic  [NUM_COLS-1:0]             press;
        logic  [NUM_COLS-1:0][CODE_W-1:0] codes;
        row_t                             row;
    } scan_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

>>> src/matrix_keypad_scanner.sv
// Top level of the 4x4 matrix keypad scanner with per-key debounce.
//
//   Channel  Handshake                  Carries
//   tick     tick_valid / tick_ready    column_levels of the row now driven low
//   cfg      cfg_valid / cfg_ready      cfg_index, cfg_data (key map words)
//   result   result_valid / result_ready key_valid, key_code, next_row, last_result
//
// A tick request is pushed into the row queue; its results are registered in the
// result stage. A tick with no press or one press gives one result, one with n
// presses gives n; ticks keep entering the two-entry row queue unless it is full.
// After reset every key is released, its history all high, the scan is on row 0 and
// the key map holds its default codes. cfg_ready is always high.
module matrix_keypad_scanner (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick_valid,
    output logic                          tick_ready,
    input  logic [mks_pkg::NUM_COLS-1:0]  column_levels,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mks_pkg::CFG_W-1:0]     cfg_data,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          key_valid,
    output logic [mks_pkg::CODE_W-1:0]    key_code,
    output logic [mks_pkg::ROW_W-1:0]     next_row,
    output logic                          last_result
);
    import mks_pkg::*;

    logic          push;
    logic          pop;
    scan_entry_t   push_entry;
    scan_entry_t   head;
    fifo_status_t  fifo_status;

    assign cfg_ready = 1'b1;

    mks_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_valid),
        .tick_ready    (tick_ready),
        .column_levels (column_levels),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fifo_status   (fifo_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    mks_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (fifo_status)
    );

    mks_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .fifo_status  (fifo_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .key_valid    (key_valid),
        .key_code     (key_code),
        .next_row     (next_row),
        .last_result  (last_result)
    );

`ifndef SYNTH
    // A tick without a press always closes with its single result.
    a_idle_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !key_valid |-> last_result && (key_code == '0))
        else $error("result without press must be last and carry a zero code");

    // The rest of a burst follows at once and belongs to the same row.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !last_result |=>
            result_valid && key_valid && (next_row == $past(next_row)))
        else $error("press burst broken or row changed inside a burst");

    // Results are never taken from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_status.empty)
        else $error("row queue popped while empty");
`endif

endmodule

>>> src/mks_front.sv
// Scan front end: key map registers, per-key sample history and debounce, row counter.
module mks_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick_valid,
    output logic                          tick_ready,
    input  logic [mks_pkg::NUM_COLS-1:0]  column_levels,
    input  logic                          cfg_valid,
    input  logic [mks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mks_pkg::CFG_W-1:0]     cfg_data,
    input  mks_pkg::fifo_status_t         fifo_status,
    output logic                          push,
    output mks_pkg::scan_entry_t          push_entry
);
    import mks_pkg::*;

    cfg_word_t              cfg_reg  [NUM_REGS];
    logic [HIST_BITS-1:0]   hist_reg [NUM_KEYS];
    logic [NUM_KEYS-1:0]    deb_reg;
    row_t                   row_reg;

    logic [HIST_BITS-1:0]   hist_next [NUM_COLS];
    logic [NUM_COLS-1:0]    deb_next;

    assign tick_ready = !fifo_status.full;
    assign push       = tick_valid && tick_ready;

    always_comb
    begin
        logic [KEY_W-1:0]     key;
        logic [HIST_BITS-1:0] h;
        cfg_word_t            word;
        push_entry.row = row_reg + 1'b1;
        for (int c = 0; c < NUM_COLS; c++)
        begin
            key  = {row_reg, COL_W'(c)};
            h    = {hist_reg[key][HIST_BITS-2:0], column_levels[c]};
            word = cfg_reg[key[KEY_W-1:1]];
            hist_next[c] = h;
            if (h == '1)
            begin
                deb_next[c] = 1'b1;
            end
            else if (h == '0)
            begin
                deb_next[c] = 1'b0;
            end
            else
            begin
                deb_next[c] = deb_reg[key];
            end
            // A press event is a released key whose whole history went low.
            push_entry.press[c] = (h == '0) && deb_reg[key];
            push_entry.codes[c] = key[0] ? word[2*CODE_W-1:CODE_W] : word[CODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                cfg_reg[r] <= KEYCODE_RESET[r];
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            cfg_reg[cfg_index[REG_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            deb_reg <= '1;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                hist_reg[k] <= '1;
            end
        end
        else if (push)
        begin
            row_reg <= row_reg + 1'b1;
            for (int c = 0; c < NUM_COLS; c++)
            begin
                hist_reg[{row_reg, COL_W'(c)}] <= hist_next[c];
                deb_reg[{row_reg, COL_W'(c)}]  <= deb_next[c];
            end
        end
    end

endmodule

>>> src/mks_fifo.sv
// Short queue of scanned rows between the front end and the result stage.
module mks_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mks_pkg::scan_entry_t  push_entry,
    input  logic                  pop,
    output mks_pkg::scan_entry_t  head,
    output mks_pkg::fifo_status_t status
);
    import mks_pkg::*;

    scan_entry_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/mks_back.sv
// Result stage: per row, one result per press, lowest column first, or one if none.
module mks_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mks_pkg::scan_entry_t       head,
    input  mks_pkg::fifo_status_t      fifo_status,
    output logic                       pop,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic                       key_valid,
    output logic [mks_pkg::CODE_W-1:0] key_code,
    output logic [mks_pkg::ROW_W-1:0]  next_row,
    output logic                       last_result
);
    import mks_pkg::*;

    scan_entry_t          held_reg;
    logic                 busy_reg;
    logic                 out_valid_reg;
    logic                 key_valid_reg;
    code_t                key_code_reg;
    row_t                 next_row_reg;
    logic                 last_reg;

    scan_entry_t          src;
    logic                 src_avail;
    logic                 load;
    logic [COL_W-1:0]     sel;
    logic [NUM_COLS-1:0]  rem;

    assign src       = busy_reg ? held_reg : head;
    assign src_avail = busy_reg || !fifo_status.empty;
    assign load      = src_avail && (!out_valid_reg || result_ready);
    assign pop       = load && !busy_reg;
    // Clearing the lowest set bit leaves the presses still to be sent.
    assign rem       = src.press & (src.press - 1'b1);

    always_comb
    begin
        sel = '0;
        for (int c = NUM_COLS - 1; c >= 0; c--)
        begin
            if (src.press[c])
            begin
                sel = COL_W'(c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg      <= (rem != '0);
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg.press <= rem;
            held_reg.codes <= src.codes;
            held_reg.row   <= src.row;
            key_valid_reg  <= (src.press != '0);
            key_code_reg   <= (src.press != '0) ? src.codes[sel] : '0;
            next_row_reg   <= src.row;
            last_reg       <= (rem == '0);
        end
    end

    assign result_valid = out_valid_reg;
    assign key_valid    = key_valid_reg;
    assign key_code     = key_code_reg;
    assign next_row     = next_row_reg;
    assign last_result  = last_reg;

endmodule
